[hdl/rasm_pkg.sv]
// ----------------------------------------------------------------------------
// rasm_pkg
// Shared types and constants for the range add / range sum block.
// ----------------------------------------------------------------------------
package rasm_pkg;

	localparam int DEPTH      = 1024;
	localparam int BLOCK      = 32;
	localparam int NUM_BLOCKS = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int BLK_SH     = $clog2(BLOCK);
	localparam int BIDX_W     = $clog2(NUM_BLOCKS);

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_LD_WR,
		ST_WALK,
		ST_EL_WR,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic ld_wr;
		logic walk_step;
		logic walk_wr;
		logic div_init;
		logic div_step;
		logic fix;
		logic set_bad;
	} ctl_t;

	typedef struct packed {
		logic is_load;
		logic is_add;
		logic is_query;
		logic neg;
		logic load_ok;
		logic more;
		logic whole;
		logic clr_last;
		logic div_last;
	} stat_t;

endpackage

[hdl/rasm_ctrl.sv]
// ----------------------------------------------------------------------------
// rasm_ctrl
// Sequencer: clearing pass, command dispatch, range walk, modulus reduction.
// ----------------------------------------------------------------------------
module rasm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  rasm_pkg::stat_t st,
	output rasm_pkg::ctl_t  ctl,
	output logic            busy,
	output logic            done
);

	rasm_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rasm_pkg::ST_CLEAR;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			rasm_pkg::ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (st.clr_last) state_nx = rasm_pkg::ST_IDLE;
			end
			rasm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.capture = 1'b1;
					state_nx    = rasm_pkg::ST_DISP;
				end
			end
			rasm_pkg::ST_DISP: begin
				if (st.is_load) begin
					state_nx = st.load_ok ? rasm_pkg::ST_LD_WR : rasm_pkg::ST_IDLE;
				end else if (st.is_add) begin
					state_nx = rasm_pkg::ST_WALK;
				end else if (st.is_query) begin
					if (st.neg) begin
						ctl.set_bad = 1'b1;
						state_nx    = rasm_pkg::ST_OUT;
					end else begin
						state_nx = rasm_pkg::ST_WALK;
					end
				end else begin
					state_nx = rasm_pkg::ST_IDLE;
				end
			end
			rasm_pkg::ST_LD_WR: begin
				ctl.ld_wr = 1'b1;
				state_nx  = rasm_pkg::ST_IDLE;
			end
			rasm_pkg::ST_WALK: begin
				if (!st.more) begin
					state_nx = st.is_query ? rasm_pkg::ST_DIV_INIT : rasm_pkg::ST_IDLE;
				end else begin
					ctl.walk_step = 1'b1;
					if (!st.whole) state_nx = rasm_pkg::ST_EL_WR;
				end
			end
			rasm_pkg::ST_EL_WR: begin
				ctl.walk_wr = 1'b1;
				state_nx    = rasm_pkg::ST_WALK;
			end
			rasm_pkg::ST_DIV_INIT: begin
				ctl.div_init = 1'b1;
				state_nx     = rasm_pkg::ST_DIV;
			end
			rasm_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
				if (st.div_last) state_nx = rasm_pkg::ST_FIX;
			end
			rasm_pkg::ST_FIX: begin
				ctl.fix  = 1'b1;
				state_nx = rasm_pkg::ST_OUT;
			end
			rasm_pkg::ST_OUT: begin
				done     = 1'b1;
				state_nx = rasm_pkg::ST_IDLE;
			end
			default: state_nx = rasm_pkg::ST_IDLE;
		endcase
	end

endmodule

[hdl/rasm_dp.sv]
// ----------------------------------------------------------------------------
// rasm_dp
// Element memory, block sums and tags, walk index, accumulator and divider.
// ----------------------------------------------------------------------------
module rasm_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rasm_pkg::ctl_t      ctl,
	output rasm_pkg::stat_t     st,
	input  logic [1:0]          command,
	input  logic [9:0]          left_index,
	input  logic [9:0]          right_index,
	input  logic signed [31:0]  value,
	output logic [30:0]         range_sum,
	output logic                bad_modulus
);

	localparam int IW = rasm_pkg::IDX_W + 1;
	localparam int BW = IW - rasm_pkg::BLK_SH;

	logic [63:0] mem [rasm_pkg::DEPTH];
	logic [63:0] bsum_q [rasm_pkg::NUM_BLOCKS];
	logic [63:0] btag_q [rasm_pkg::NUM_BLOCKS];

	logic [1:0]    op_q;
	logic [IW-1:0] i_q;
	logic [9:0]    r_q;
	logic [63:0]   v_q;
	logic [63:0]   total_q;
	logic [63:0]   rd_q;
	logic [31:0]   rem_q;
	logic [63:0]   mag_q;
	logic          negt_q;
	logic [5:0]    cnt_q;
	logic [rasm_pkg::IDX_W-1:0] clr_q;
	logic [30:0]   res_q;
	logic          bad_q;

	logic [BW-1:0]                 blk;
	logic                          has;
	logic [rasm_pkg::BIDX_W-1:0]   bidx;
	logic [63:0]                   tag;
	logic [31:0]                   m;
	logic [32:0]                   rem2;
	logic [32:0]                   rem_sub;
	logic                          is_add, is_query;
	logic                          we;
	logic [rasm_pkg::IDX_W-1:0]    wa;
	logic [63:0]                   wd;
	logic [9:0]                    r_c;

	assign blk      = i_q[IW-1:rasm_pkg::BLK_SH];
	assign has      = blk < BW'(rasm_pkg::NUM_BLOCKS);
	assign bidx     = blk[rasm_pkg::BIDX_W-1:0];
	assign tag      = has ? btag_q[bidx] : 64'd0;
	assign m        = v_q[31:0] + 32'd1;
	assign rem2     = {rem_q, mag_q[63]};
	assign rem_sub  = rem2 - {1'b0, m};
	assign is_add   = op_q == rasm_pkg::CMD_ADD;
	assign is_query = op_q == rasm_pkg::CMD_QUERY;
	assign r_c      = ({1'b0, right_index} > 11'(rasm_pkg::DEPTH - 1)) ?
	                  10'(rasm_pkg::DEPTH - 1) : right_index;

	always_comb begin
		st          = '0;
		st.is_load  = op_q == rasm_pkg::CMD_LOAD;
		st.is_add   = is_add;
		st.is_query = is_query;
		st.neg      = v_q[63];
		st.load_ok  = i_q < IW'(rasm_pkg::DEPTH);
		st.more     = (i_q <= IW'(r_q)) && (i_q < IW'(rasm_pkg::DEPTH));
		st.whole    = (i_q[rasm_pkg::BLK_SH-1:0] == '0) && has &&
		              ((12'(i_q) + 12'(rasm_pkg::BLOCK - 1)) <= 12'(r_q));
		st.clr_last = clr_q == rasm_pkg::IDX_W'(rasm_pkg::DEPTH - 1);
		st.div_last = cnt_q == 6'd63;
	end

	// element memory
	always_comb begin
		we = ctl.clr_wr | ctl.ld_wr | (ctl.walk_wr & is_add);
		wa = ctl.clr_wr ? clr_q : i_q[rasm_pkg::IDX_W-1:0];
		if (ctl.clr_wr) wd = 64'd0;
		else if (ctl.ld_wr) wd = v_q - tag;
		else wd = rd_q + v_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[i_q[rasm_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// block sums and tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < rasm_pkg::NUM_BLOCKS; k++) begin
				bsum_q[k] <= 64'd0;
				btag_q[k] <= 64'd0;
			end
		end else begin
			if (ctl.ld_wr && has) begin
				bsum_q[bidx] <= bsum_q[bidx] + v_q - rd_q - tag;
			end
			if (ctl.walk_step && st.whole && is_add) begin
				btag_q[bidx] <= btag_q[bidx] + v_q;
				bsum_q[bidx] <= bsum_q[bidx] + (v_q << rasm_pkg::BLK_SH);
			end
			if (ctl.walk_wr && is_add && has) begin
				bsum_q[bidx] <= bsum_q[bidx] + v_q;
			end
		end
	end

	// command word, walk index and accumulator
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q    <= command;
			i_q     <= IW'(left_index);
			r_q     <= r_c;
			v_q     <= {{32{value[31]}}, value};
			total_q <= 64'd0;
		end else begin
			if (ctl.walk_step && st.whole) begin
				i_q <= i_q + IW'(rasm_pkg::BLOCK);
				if (is_query) total_q <= total_q + bsum_q[bidx];
			end
			if (ctl.walk_wr) begin
				i_q <= i_q + 1'b1;
				if (is_query) total_q <= total_q + rd_q + tag;
			end
		end
	end

	// restoring divider, one bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.div_init) begin
			negt_q <= total_q[63];
			mag_q  <= total_q[63] ? (~total_q + 64'd1) : total_q;
			rem_q  <= 32'd0;
			cnt_q  <= 6'd0;
		end else if (ctl.div_step) begin
			rem_q <= rem_sub[32] ? rem2[31:0] : rem_sub[31:0];
			mag_q <= mag_q << 1;
			cnt_q <= cnt_q + 6'd1;
		end
		if (ctl.fix) begin
			res_q <= (negt_q && rem_q != 32'd0) ? 31'(m - rem_q) : rem_q[30:0];
			bad_q <= 1'b0;
		end else if (ctl.set_bad) begin
			res_q <= 31'd0;
			bad_q <= 1'b1;
		end
	end

	assign range_sum   = res_q;
	assign bad_modulus = bad_q;

endmodule

[hdl/range_add_range_sum_mod_core.sv]
// ----------------------------------------------------------------------------
// range_add_range_sum_mod_core
// Range add and range sum modulo over a block-decomposed element array.
// Load writes one in-range element; add walks the range by whole blocks and edge elements.
// Query does the add walk, then a 64-step divider and a sign fix up to done.
// One command at a time: busy stays high until the command completes.
// After reset a clearing pass of the element memory holds busy.
// ----------------------------------------------------------------------------
module range_add_range_sum_mod_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [9:0]         left_index,
	input  logic [9:0]         right_index,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [30:0]        range_sum,
	output logic               bad_modulus
);

	rasm_pkg::ctl_t  ctl;
	rasm_pkg::stat_t st;

	rasm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	rasm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.st          (st),
		.command     (command),
		.left_index  (left_index),
		.right_index (right_index),
		.value       (value),
		.range_sum   (range_sum),
		.bad_modulus (bad_modulus)
	);

endmodule
